[hw/rtl/assert_macros.svh]
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GMT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define GMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/gmt_pkg.sv]
// types, codes and helpers of the membership table
package gmt_pkg;

  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned SLOT_W    = $clog2(MAX_NODES);
  localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1);
  localparam int unsigned KEY_W     = 48;

  localparam logic [3:0] OP_UP        = 4'd0;
  localparam logic [3:0] OP_DOWN      = 4'd1;
  localparam logic [3:0] OP_SUSPECT   = 4'd2;
  localparam logic [3:0] OP_RECOVER   = 4'd3;
  localparam logic [3:0] OP_ACTOR_DN  = 4'd4;
  localparam logic [3:0] OP_ACTOR_UP  = 4'd5;
  localparam logic [3:0] OP_PING_OK   = 4'd6;
  localparam logic [3:0] OP_PING_FAIL = 4'd7;
  localparam logic [3:0] OP_MERGE     = 4'd8;
  localparam logic [3:0] OP_FULL      = 4'd9;

  localparam logic [2:0] KIND_UP      = 3'd0;
  localparam logic [2:0] KIND_DOWN    = 3'd1;
  localparam logic [2:0] KIND_SUSPECT = 3'd2;
  localparam logic [2:0] KIND_RECOVER = 3'd3;
  localparam logic [2:0] KIND_ACT_DN  = 3'd4;
  localparam logic [2:0] KIND_ACT_UP  = 3'd5;

  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_SELF    = 2'd1;
  localparam logic [1:0] ST_STALE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] CFG_SELF_ADDR = 2'd0;
  localparam logic [1:0] CFG_SELF_PORT = 2'd1;
  localparam logic [1:0] CFG_RT_MULT   = 2'd2;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] node_address;
    logic [15:0] node_port;
    logic [31:0] node_uid;
    logic [31:0] incarnation;
    logic        actor_known;
    logic        actor_up;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             disseminate;
    logic [2:0]       gossip_kind;
    logic [31:0]      gossip_incarnation;
    logic [5:0]       retransmit_count;
    logic             notify;
    logic [CNT_W-1:0] member_count;
    logic [CNT_W-1:0] suspect_count;
  } rsp_t;

  typedef struct packed {
    logic        mp;
    logic        sp;
    logic [31:0] mi;
    logic [31:0] mu;
    logic [31:0] si;
    logic [31:0] su;
    logic        af;
  } entry_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] hit_idx;
    entry_t            ent;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } token_t;

  // write request broadcast to the row
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    entry_t            ent;
    logic              wr_key;
    logic              wr_mi;
    logic              wr_mu;
    logic              wr_si;
    logic              wr_su;
    logic              wr_af;
  } wr_t;

  // multiplier times ceil(log10(count)), zero for an empty set
  function automatic logic [5:0] rc_calc(logic [3:0] mult, logic [CNT_W-1:0] cnt);
    logic [31:0] c;
    logic [2:0]  d;
    logic [6:0]  p;
    c = 32'(cnt);
    d = 3'(c > 32'd1) + 3'(c > 32'd10) + 3'(c > 32'd100) + 3'(c > 32'd1000);
    p = 7'(mult) * 7'(d);
    return p[5:0];
  endfunction

endpackage

[hw/rtl/gossip_membership_table_top.sv]
// top level of the membership table: controller and row of slot cells
// Membership table for a gossip cluster, one event per request.
// Input channel: in_valid_i/in_ready_o carry one event (in_req_i); output
// channel: out_valid_o/out_ready_i carry exactly one result per event.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 self address, 1 self port, 2 retransmit multiplier) with no wait;
// write only while the block is idle.
// Each request runs a search token down the row of MAX_NODES slot cells,
// one cell per cycle, collecting the matching slot and the first free slot;
// the update is then written back to the cell of that slot.
// One request is in flight at a time: a new request is taken only once the
// previous one has run the whole cell row and its result has been registered.
// A finished result sits in the output register; a new request is taken
// while it waits, but its own result holds back until the receiver takes
// the previous one.
// Reset: slot zero holds this node as member, all other slots free, one
// member and no suspects, retransmit multiplier 3; no clearing pass.
module gossip_membership_table_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gmt_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gmt_pkg::rsp_t  out_rsp_o
);

  logic [gmt_pkg::KEY_W-1:0] key;
  logic [gmt_pkg::KEY_W-1:0] self_key;
  gmt_pkg::wr_t              wr;
  gmt_pkg::token_t           tok [gmt_pkg::MAX_NODES+1];

  assign tok[0] = '0;

  gmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .key_o       (key),
    .self_key_o  (self_key),
    .tok_i       (tok[gmt_pkg::MAX_NODES]),
    .wr_o        (wr)
  );

  for (genvar i = 0; i < gmt_pkg::MAX_NODES; i++) begin : g_cell
    gmt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (gmt_pkg::SLOT_W'(i)),
      .key_i      (key),
      .self_key_i (self_key),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .wr_i       (wr)
    );
  end

endmodule

[hw/rtl/gmt_cell.sv]
// one table slot: holds an entry, merges the passing search token
module gmt_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gmt_pkg::SLOT_W-1:0]  slot_idx_i,
  input  logic [gmt_pkg::KEY_W-1:0]   key_i,
  input  logic [gmt_pkg::KEY_W-1:0]   self_key_i,
  input  gmt_pkg::token_t             tok_i,
  output gmt_pkg::token_t             tok_o,
  input  gmt_pkg::wr_t                wr_i
);

  logic [gmt_pkg::KEY_W-1:0] key_q;
  gmt_pkg::entry_t           ent_q, ent_d;
  gmt_pkg::token_t           tok_q, tok_d;
  logic                      is_head, used, hit;

  assign is_head = (slot_idx_i == '0);
  assign used    = ent_q.mp | ent_q.sp;
  // slot zero always stands for this node
  assign hit     = is_head ? (key_i == self_key_i) : (used && key_q == key_i);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.found && hit) begin
      tok_d.found   = 1'b1;
      tok_d.hit_idx = slot_idx_i;
      tok_d.ent     = ent_q;
    end
    if (!tok_i.free_found && !is_head && !used) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = slot_idx_i;
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (wr_i.en && wr_i.idx == slot_idx_i) begin
      ent_d.mp = wr_i.ent.mp;
      ent_d.sp = wr_i.ent.sp;
      if (wr_i.wr_mi) ent_d.mi = wr_i.ent.mi;
      if (wr_i.wr_mu) ent_d.mu = wr_i.ent.mu;
      if (wr_i.wr_si) ent_d.si = wr_i.ent.si;
      if (wr_i.wr_su) ent_d.su = wr_i.ent.su;
      if (wr_i.wr_af) ent_d.af = wr_i.ent.af;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '{mp: is_head, default: '0};
      tok_q <= '0;
      key_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
      if (wr_i.en && wr_i.wr_key && wr_i.idx == slot_idx_i) begin
        key_q <= wr_i.key;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

[hw/rtl/gmt_ctrl.sv]
// request sequencing, update rules, counts and result register
module gmt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  gmt_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gmt_pkg::rsp_t              out_rsp_o,
  output logic [gmt_pkg::KEY_W-1:0]  key_o,
  output logic [gmt_pkg::KEY_W-1:0]  self_key_o,
  input  gmt_pkg::token_t            tok_i,
  output gmt_pkg::wr_t               wr_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic                        state_q, state_d;
  logic [gmt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  gmt_pkg::req_t               req_q;
  logic [31:0]                 self_addr_q;
  logic [15:0]                 self_port_q;
  logic [3:0]                  mult_q;
  logic [gmt_pkg::CNT_W-1:0]   members_q, suspects_q;
  gmt_pkg::rsp_t               rsp_q, rsp_d;
  logic                        out_valid_q;
  logic                        done, finish;
  gmt_pkg::entry_t             e;
  gmt_pkg::wr_t                wr;
  logic [gmt_pkg::CNT_W-1:0]   mcnt, scnt;
  logic                        found, clr, do_sus, do_rec;
  logic [31:0]                 sus_inc, rec_inc, inc, uid;
  logic [gmt_pkg::SLOT_W-1:0]  s;

  assign key_o      = {req_q.node_address, req_q.node_port};
  assign self_key_o = {self_addr_q, self_port_q};
  assign in_ready_o = (state_q == S_IDLE);
  assign done       = (state_q == S_SRCH) && (cnt_q == gmt_pkg::CNT_W'(gmt_pkg::MAX_NODES));
  assign finish     = done && (!out_valid_q || out_ready_i);

  // update rules on the entry brought back by the token
  always_comb begin
    e       = tok_i.ent;
    found   = tok_i.found;
    s       = tok_i.hit_idx;
    mcnt    = members_q;
    scnt    = suspects_q;
    inc     = req_q.incarnation;
    uid     = req_q.node_uid;
    clr     = 1'b0;
    do_sus  = 1'b0;
    do_rec  = 1'b0;
    sus_inc = inc;
    rec_inc = '0;
    wr      = '0;
    rsp_d   = '0;
    rsp_d.status = gmt_pkg::ST_STALE;
    if (!found) begin
      e.mp = 1'b0;
      e.sp = 1'b0;
    end
    case (req_q.op)
      gmt_pkg::OP_UP: begin
        if (found && s == '0) begin
          rsp_d.status = gmt_pkg::ST_SELF;
        end else begin
          if (found) begin
            // a different instance id expires the stored entry
            if (e.mp && e.mu != uid) begin
              e.mp = 1'b0; mcnt = mcnt - gmt_pkg::CNT_W'(1); clr = 1'b1;
            end
            if (e.sp && e.su != uid) begin
              e.sp = 1'b0; scnt = scnt - gmt_pkg::CNT_W'(1); clr = 1'b1;
            end
            if (clr) begin
              e.af = 1'b0; wr.wr_af = 1'b1; rsp_d.notify = 1'b1;
              rsp_d.status = gmt_pkg::ST_APPLIED; wr.en = 1'b1;
            end
          end
          if ((e.sp && e.si >= inc) || (e.mp && e.mi >= inc)) begin
            // stale
          end else if (!found && !tok_i.free_found) begin
            rsp_d.status = gmt_pkg::ST_FULL;
          end else begin
            if (!found) begin
              s = tok_i.free_idx; wr.wr_key = 1'b1;
            end
            rsp_d.disseminate = 1'b1; rsp_d.gossip_kind = gmt_pkg::KIND_UP;
            rsp_d.gossip_incarnation = inc; rsp_d.status = gmt_pkg::ST_APPLIED;
            rsp_d.retransmit_count = gmt_pkg::rc_calc(mult_q, mcnt);
            if (!e.mp) begin
              e.mu = uid; wr.wr_mu = 1'b1; e.mp = 1'b1; mcnt = mcnt + gmt_pkg::CNT_W'(1);
            end
            e.mi = inc; wr.wr_mi = 1'b1; rsp_d.notify = 1'b1; wr.en = 1'b1;
          end
        end
      end
      gmt_pkg::OP_DOWN: begin
        if (e.mp || e.sp) begin
          rsp_d.disseminate = 1'b1; rsp_d.gossip_kind = gmt_pkg::KIND_DOWN;
          rsp_d.gossip_incarnation = inc; rsp_d.status = gmt_pkg::ST_APPLIED;
          rsp_d.retransmit_count = gmt_pkg::rc_calc(mult_q, mcnt);
          if (s == '0) begin
            rsp_d.status = gmt_pkg::ST_SELF;
          end else begin
            if (e.mp) mcnt = mcnt - gmt_pkg::CNT_W'(1);
            if (e.sp) scnt = scnt - gmt_pkg::CNT_W'(1);
            e.mp = 1'b0; e.sp = 1'b0; e.af = 1'b0; wr.wr_af = 1'b1;
            rsp_d.notify = 1'b1; wr.en = 1'b1;
          end
        end
      end
      gmt_pkg::OP_SUSPECT: begin
        if (e.sp) begin
          if (e.si < inc) begin
            e.si = inc; wr.wr_si = 1'b1; rsp_d.status = gmt_pkg::ST_APPLIED; wr.en = 1'b1;
          end
        end else if (e.mp && inc >= e.mi) begin
          do_sus = 1'b1;
        end
      end
      gmt_pkg::OP_RECOVER: begin
        if (e.sp && inc >= e.si) do_rec = 1'b1;
      end
      gmt_pkg::OP_ACTOR_DN, gmt_pkg::OP_ACTOR_UP: begin
        if (e.mp && e.mi < inc) begin
          rsp_d.disseminate = 1'b1; rsp_d.gossip_kind = req_q.op[2:0];
          rsp_d.gossip_incarnation = inc; rsp_d.status = gmt_pkg::ST_APPLIED;
          rsp_d.retransmit_count = gmt_pkg::rc_calc(mult_q, mcnt);
          e.mi = inc; wr.wr_mi = 1'b1;
          e.af = (req_q.op == gmt_pkg::OP_ACTOR_UP); wr.wr_af = 1'b1;
          rsp_d.notify = 1'b1; wr.en = 1'b1;
        end
      end
      gmt_pkg::OP_PING_OK: begin
        if (e.sp) do_rec = 1'b1;
      end
      gmt_pkg::OP_PING_FAIL: begin
        if (e.mp) begin
          do_sus = 1'b1; sus_inc = e.mi;
        end
      end
      gmt_pkg::OP_MERGE: begin
        if (e.mp) begin
          if (inc > e.mi) begin
            e.mi = inc; wr.wr_mi = 1'b1;
            if (req_q.actor_known) begin
              e.af = req_q.actor_up; wr.wr_af = 1'b1;
            end
            rsp_d.notify = 1'b1; rsp_d.status = gmt_pkg::ST_APPLIED; wr.en = 1'b1;
          end
        end else if (!found && !tok_i.free_found) begin
          rsp_d.status = gmt_pkg::ST_FULL;
        end else begin
          if (!found) begin
            s = tok_i.free_idx; wr.wr_key = 1'b1;
          end
          e.mu = uid; wr.wr_mu = 1'b1; e.mp = 1'b1; mcnt = mcnt + gmt_pkg::CNT_W'(1);
          e.mi = inc; wr.wr_mi = 1'b1;
          if (req_q.actor_known) begin
            e.af = req_q.actor_up; wr.wr_af = 1'b1;
          end
          rsp_d.notify = 1'b1; rsp_d.status = gmt_pkg::ST_APPLIED; wr.en = 1'b1;
        end
      end
      gmt_pkg::OP_FULL: begin
        if (!e.mp && !found && !tok_i.free_found) begin
          rsp_d.status = gmt_pkg::ST_FULL;
        end else begin
          if (!e.mp) begin
            if (!found) begin
              s = tok_i.free_idx; wr.wr_key = 1'b1;
            end
            e.mu = uid; wr.wr_mu = 1'b1; e.mp = 1'b1; mcnt = mcnt + gmt_pkg::CNT_W'(1);
            e.mi = '0; wr.wr_mi = 1'b1;
          end
          e.af = req_q.actor_up; wr.wr_af = 1'b1;
          rsp_d.notify = 1'b1; rsp_d.status = gmt_pkg::ST_APPLIED; wr.en = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_sus) begin
      if (!e.sp) begin
        e.su = uid; wr.wr_su = 1'b1; e.sp = 1'b1; scnt = scnt + gmt_pkg::CNT_W'(1);
      end
      e.si = sus_inc; wr.wr_si = 1'b1;
      if (e.mp) mcnt = mcnt - gmt_pkg::CNT_W'(1);
      e.mp = 1'b0; e.af = 1'b0; wr.wr_af = 1'b1;
      rsp_d.disseminate = 1'b1; rsp_d.gossip_kind = gmt_pkg::KIND_SUSPECT;
      rsp_d.gossip_incarnation = sus_inc; rsp_d.status = gmt_pkg::ST_APPLIED;
      rsp_d.retransmit_count = gmt_pkg::rc_calc(mult_q, mcnt);
      rsp_d.notify = 1'b1; wr.en = 1'b1;
    end
    if (do_rec) begin
      rec_inc = e.si;
      if (!e.mp) begin
        e.mu = uid; wr.wr_mu = 1'b1; e.mp = 1'b1; mcnt = mcnt + gmt_pkg::CNT_W'(1);
      end
      e.mi = rec_inc; wr.wr_mi = 1'b1;
      if (e.sp) scnt = scnt - gmt_pkg::CNT_W'(1);
      e.sp = 1'b0;
      rsp_d.disseminate = 1'b1; rsp_d.gossip_kind = gmt_pkg::KIND_RECOVER;
      rsp_d.gossip_incarnation = rec_inc; rsp_d.status = gmt_pkg::ST_APPLIED;
      rsp_d.retransmit_count = gmt_pkg::rc_calc(mult_q, mcnt);
      rsp_d.notify = 1'b1; wr.en = 1'b1;
    end

    wr.idx  = s;
    wr.key  = {req_q.node_address, req_q.node_port};
    wr.ent  = e;
    wr.en   = wr.en & finish;
    rsp_d.member_count  = mcnt;
    rsp_d.suspect_count = scnt;
  end

  assign wr_o = wr;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SRCH;
          cnt_d   = '0;
        end
      end
      S_SRCH: begin
        if (!done) cnt_d = cnt_q + gmt_pkg::CNT_W'(1);
        if (finish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      members_q   <= gmt_pkg::CNT_W'(1);
      suspects_q  <= '0;
      self_addr_q <= '0;
      self_port_q <= '0;
      mult_q      <= 4'd3;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        members_q   <= rsp_d.member_count;
        suspects_q  <= rsp_d.suspect_count;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gmt_pkg::CFG_SELF_ADDR: self_addr_q <= cfg_wdata_i;
          gmt_pkg::CFG_SELF_PORT: self_port_q <= cfg_wdata_i[15:0];
          gmt_pkg::CFG_RT_MULT:   mult_q      <= cfg_wdata_i[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_req_i;
    if (finish) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

[hw/rtl/gmt_checker.sv]
// port-level checks of the membership table, bound to the top level
`include "assert_macros.svh"

module gmt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input gmt_pkg::rsp_t out_rsp_o
);

  // a stalled result holds
  `GMT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))
  // one request at a time: no accept right after an accept
  `GMT_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  // a full table queues nothing and changes nothing
  `GMT_ASSERT(a_full_quiet, out_valid_o && out_rsp_o.status == gmt_pkg::ST_FULL,
              !out_rsp_o.disseminate && !out_rsp_o.notify)
  // gossip fields are zero without gossip
  `GMT_ASSERT(a_no_gossip_zero, out_valid_o && !out_rsp_o.disseminate,
              out_rsp_o.gossip_kind == '0 && out_rsp_o.gossip_incarnation == '0 &&
              out_rsp_o.retransmit_count == '0)

endmodule

bind gossip_membership_table_top gmt_checker u_gmt_checker (.*);

[sim/gossip_membership_table_top_tb.sv]
// testbench of the membership table: directed table, random events, own prediction
module gossip_membership_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT     = gmt_pkg::MAX_NODES;
  localparam int unsigned N_RANDOM  = 400;    // per phase, four phases
  localparam int unsigned SETTLE    = 80;     // idle wait after the last result, longer than a search
  localparam int unsigned LIMIT     = 2000000;
  localparam int unsigned HOLD_LEN  = 700;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [1:0]     cfg_idx_i;
  logic [31:0]    cfg_wdata_i;
  logic           in_valid_i;
  logic           in_ready_o;
  gmt_pkg::req_t  in_req_i;
  logic           out_valid_o;
  logic           out_ready_i;
  gmt_pkg::rsp_t  out_rsp_o;

  gossip_membership_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // membership state as this bench sees it
  logic [47:0]   tbl_key [NSLOT];
  bit            tbl_mem [NSLOT];
  bit            tbl_sus [NSLOT];
  bit            tbl_act [NSLOT];
  logic [31:0]   tbl_minc [NSLOT];
  logic [31:0]   tbl_muid [NSLOT];
  logic [31:0]   tbl_sinc [NSLOT];
  logic [31:0]   tbl_suid [NSLOT];
  int unsigned   n_members;
  int unsigned   n_suspects;
  logic [31:0]   my_addr;
  logic [15:0]   my_port;
  logic [3:0]    rt_mult;
  gmt_pkg::rsp_t pred;

  gmt_pkg::rsp_t pending_rsp [$];
  int unsigned   n_errors;
  int unsigned   cycle_cnt;
  int unsigned   snd_idle;
  int unsigned   rcv_idle;
  bit            hold_go;
  bit            hold_taken;
  int unsigned   hold_left;

  typedef struct {
    gmt_pkg::req_t req;
    bit            fixed;
    gmt_pkg::rsp_t rsp;
  } row_t;
  row_t        dir_rows [$];
  logic [47:0] key_pool [72];
  logic [31:0] uid_pool [3];
  logic [47:0] old_self;

  function automatic logic [47:0] my_key();
    return {my_addr, my_port};
  endfunction

  function automatic bit lookup(logic [47:0] k, output int s);
    s = 0;
    if (k == my_key()) return 1'b1;
    for (int i = 1; i < NSLOT; i++)
      if ((tbl_mem[i] || tbl_sus[i]) && tbl_key[i] == k) begin
        s = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic bit grab_free(logic [47:0] k, output int s);
    s = 0;
    for (int i = 1; i < NSLOT; i++)
      if (!tbl_mem[i] && !tbl_sus[i]) begin
        tbl_key[i] = k;
        s = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic void put_mem(int s, bit on);
    if (tbl_mem[s] != on) begin
      if (on) n_members++;
      else n_members--;
    end
    tbl_mem[s] = on;
  endfunction

  function automatic void put_sus(int s, bit on);
    if (tbl_sus[s] != on) begin
      if (on) n_suspects++;
      else n_suspects--;
    end
    tbl_sus[s] = on;
  endfunction

  // queue a gossip; count taken from the member set size at this moment
  function automatic void queue_gossip(logic [2:0] kind, logic [31:0] inc);
    int unsigned d;
    int unsigned p;
    d = 0;
    p = 1;
    while (p < n_members) begin
      p = p * 10;
      d++;
    end
    pred.disseminate        = 1'b1;
    pred.gossip_kind        = kind;
    pred.gossip_incarnation = inc;
    pred.retransmit_count   = 6'((rt_mult * d) & 63);
    pred.status             = gmt_pkg::ST_APPLIED;
  endfunction

  function automatic void mark_suspect(int s, logic [31:0] inc, logic [31:0] uid);
    if (!tbl_mem[s]) return;
    if (!tbl_sus[s]) begin
      tbl_suid[s] = uid;
      put_sus(s, 1'b1);
    end
    tbl_sinc[s] = inc;
    put_mem(s, 1'b0);
    tbl_act[s] = 1'b0;
    queue_gossip(gmt_pkg::KIND_SUSPECT, inc);
    pred.notify = 1'b1;
  endfunction

  function automatic void mark_alive(int s, logic [31:0] uid);
    logic [31:0] inc;
    inc = tbl_sinc[s];
    if (!tbl_mem[s]) begin
      tbl_muid[s] = uid;
      put_mem(s, 1'b1);
    end
    tbl_minc[s] = inc;
    put_sus(s, 1'b0);
    queue_gossip(gmt_pkg::KIND_RECOVER, inc);
    pred.notify = 1'b1;
  endfunction

  function automatic void apply_event(gmt_pkg::req_t r);
    logic [47:0] k;
    int s;
    bit found, mp, sp, cleared;
    k = {r.node_address, r.node_port};
    found = lookup(k, s);
    mp = found && tbl_mem[s];
    sp = found && tbl_sus[s];
    pred = '0;
    pred.status = gmt_pkg::ST_STALE;
    case (r.op)
      gmt_pkg::OP_UP: begin
        if (k == my_key()) pred.status = gmt_pkg::ST_SELF;
        else begin
          if (found) begin
            cleared = 1'b0;
            if (mp && tbl_muid[s] != r.node_uid) begin
              put_mem(s, 1'b0);
              cleared = 1'b1;
              mp = 1'b0;
            end
            if (sp && tbl_suid[s] != r.node_uid) begin
              put_sus(s, 1'b0);
              cleared = 1'b1;
              sp = 1'b0;
            end
            if (cleared) begin
              tbl_act[s] = 1'b0;
              pred.notify = 1'b1;
              pred.status = gmt_pkg::ST_APPLIED;
            end
          end
          if (sp && tbl_sinc[s] >= r.incarnation) ;
          else if (mp && tbl_minc[s] >= r.incarnation) ;
          else if (!found && !grab_free(k, s)) pred.status = gmt_pkg::ST_FULL;
          else begin
            queue_gossip(gmt_pkg::KIND_UP, r.incarnation);
            if (!mp) begin
              tbl_muid[s] = r.node_uid;
              put_mem(s, 1'b1);
            end
            tbl_minc[s] = r.incarnation;
            pred.notify = 1'b1;
          end
        end
      end
      gmt_pkg::OP_DOWN: begin
        if (mp || sp) begin
          queue_gossip(gmt_pkg::KIND_DOWN, r.incarnation);
          if (s == 0) pred.status = gmt_pkg::ST_SELF;
          else begin
            put_mem(s, 1'b0);
            put_sus(s, 1'b0);
            tbl_act[s] = 1'b0;
            pred.notify = 1'b1;
          end
        end
      end
      gmt_pkg::OP_SUSPECT: begin
        if (sp) begin
          if (tbl_sinc[s] < r.incarnation) begin
            tbl_sinc[s] = r.incarnation;
            pred.status = gmt_pkg::ST_APPLIED;
          end
        end else if (mp && r.incarnation >= tbl_minc[s])
          mark_suspect(s, r.incarnation, r.node_uid);
      end
      gmt_pkg::OP_RECOVER: begin
        if (sp && r.incarnation >= tbl_sinc[s]) mark_alive(s, r.node_uid);
      end
      gmt_pkg::OP_ACTOR_DN, gmt_pkg::OP_ACTOR_UP: begin
        if (mp && tbl_minc[s] < r.incarnation) begin
          queue_gossip((r.op == gmt_pkg::OP_ACTOR_UP) ? gmt_pkg::KIND_ACT_UP :
                       gmt_pkg::KIND_ACT_DN, r.incarnation);
          tbl_minc[s] = r.incarnation;
          tbl_act[s] = (r.op == gmt_pkg::OP_ACTOR_UP);
          pred.notify = 1'b1;
        end
      end
      gmt_pkg::OP_PING_OK: begin
        if (sp) mark_alive(s, r.node_uid);
      end
      gmt_pkg::OP_PING_FAIL: begin
        if (mp) mark_suspect(s, tbl_minc[s], r.node_uid);
      end
      gmt_pkg::OP_MERGE: begin
        if (mp) begin
          if (r.incarnation > tbl_minc[s]) begin
            tbl_minc[s] = r.incarnation;
            if (r.actor_known) tbl_act[s] = r.actor_up;
            pred.notify = 1'b1;
            pred.status = gmt_pkg::ST_APPLIED;
          end
        end else if (!found && !grab_free(k, s)) pred.status = gmt_pkg::ST_FULL;
        else begin
          tbl_muid[s] = r.node_uid;
          put_mem(s, 1'b1);
          tbl_minc[s] = r.incarnation;
          if (r.actor_known) tbl_act[s] = r.actor_up;
          pred.notify = 1'b1;
          pred.status = gmt_pkg::ST_APPLIED;
        end
      end
      gmt_pkg::OP_FULL: begin
        if (!mp && !found && !grab_free(k, s)) pred.status = gmt_pkg::ST_FULL;
        else begin
          if (!mp) begin
            tbl_muid[s] = r.node_uid;
            put_mem(s, 1'b1);
            tbl_minc[s] = '0;
          end
          tbl_act[s] = r.actor_up;
          pred.notify = 1'b1;
          pred.status = gmt_pkg::ST_APPLIED;
        end
      end
      default: ;
    endcase
    pred.member_count  = gmt_pkg::CNT_W'(n_members);
    pred.suspect_count = gmt_pkg::CNT_W'(n_suspects);
  endfunction

  function automatic void add_row(logic [3:0] op, logic [31:0] addr, logic [15:0] port,
                                  logic [31:0] uid, logic [31:0] inc, bit known, bit aup,
                                  bit fixed, gmt_pkg::rsp_t rsp);
    row_t r;
    r.req   = '{op, addr, port, uid, inc, known, aup};
    r.fixed = fixed;
    r.rsp   = rsp;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic gmt_pkg::req_t random_event(int unsigned npool);
    gmt_pkg::req_t r;
    logic [47:0] k;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) k = my_key();
    else if (sel < 9) k = old_self;
    else k = key_pool[$urandom_range(npool - 1)];
    r.node_address = k[47:16];
    r.node_port    = k[15:0];
    sel = $urandom_range(99);
    if (sel < 3) r.op = 4'($urandom_range(15, 10));
    else if (npool > 60 && sel < 55) r.op = (sel < 30) ? gmt_pkg::OP_MERGE : gmt_pkg::OP_FULL;
    else r.op = 4'($urandom_range(9));
    r.node_uid = ($urandom_range(3) == 0) ? uid_pool[$urandom_range(2)] : uid_pool[0];
    sel = $urandom_range(99);
    if (sel < 5) r.incarnation = $urandom;
    else if (sel < 7) r.incarnation = '1;
    else r.incarnation = 32'($urandom_range(6));
    r.actor_known = 1'($urandom);
    r.actor_up    = 1'($urandom);
    return r;
  endfunction

  task automatic send_event(gmt_pkg::req_t r, bit fixed, gmt_pkg::rsp_t rsp);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    apply_event(r);
    pending_rsp.insert(pending_rsp.size(), fixed ? rsp : pred);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      gmt_pkg::CFG_SELF_ADDR: my_addr = data;
      gmt_pkg::CFG_SELF_PORT: my_port = data[15:0];
      gmt_pkg::CFG_RT_MULT:   rt_mult = data[3:0];
      default: ;
    endcase
  endtask

  task automatic new_setting(logic [31:0] addr, logic [15:0] port, logic [3:0] mult);
    old_self = my_key();
    write_reg(gmt_pkg::CFG_SELF_ADDR, addr);
    write_reg(gmt_pkg::CFG_SELF_PORT, {16'h0, port});
    write_reg(gmt_pkg::CFG_RT_MULT, {28'h0, mult});
  endtask

  task automatic random_phase(int unsigned npool);
    for (int i = 0; i < N_RANDOM; i++) send_event(random_event(npool), 1'b0, '0);
    wait_idle();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: checks each result, stalls at random, one long hold-off on request
  always @(posedge clk_i) begin
    gmt_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_rsp_o);
        n_errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o !== want) begin
          $display("%0t: result mismatch: expected %p, actual %p", $realtime, want,
                   out_rsp_o);
          n_errors++;
        end
      end
    end
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    gmt_pkg::rsp_t r0;
    logic [31:0] uid_a, addr_a, addr_b;
    logic [15:0] port_a, port_b;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = gmt_pkg::CFG_SELF_ADDR;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    n_errors    = 0;
    cycle_cnt   = 0;
    hold_go     = 1'b0;
    hold_taken  = 1'b0;
    hold_left   = 0;
    snd_idle    = 22;
    rcv_idle    = 53;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_key[i] = '0; tbl_mem[i] = 1'b0; tbl_sus[i] = 1'b0; tbl_act[i] = 1'b0;
      tbl_minc[i] = '0; tbl_muid[i] = '0; tbl_sinc[i] = '0; tbl_suid[i] = '0;
    end
    tbl_mem[0] = 1'b1;
    n_members  = 1;
    n_suspects = 0;
    my_addr    = '0;
    my_port    = '0;
    rt_mult    = 4'd3;
    old_self   = '0;
    foreach (key_pool[i]) key_pool[i] = {32'($urandom), 16'($urandom)};
    foreach (uid_pool[i]) uid_pool[i] = $urandom;

    uid_a  = 32'h1234_5678;
    addr_a = 32'h0A00_0001;
    port_a = 16'd7946;
    addr_b = 32'hC0A8_0102;
    port_b = 16'h1F90;
    r0 = '0;
    // the expected rows start from reset: self is 0:0, multiplier 3
    add_row(gmt_pkg::OP_UP, '0, '0, uid_a, 32'd1, 1'b0, 1'b0, 1'b1,
            '{gmt_pkg::ST_SELF, 1'b0, gmt_pkg::KIND_UP, 32'd0, 6'd0, 1'b0,
              gmt_pkg::CNT_W'(1), gmt_pkg::CNT_W'(0)});
    add_row(4'd15, addr_a, port_a, uid_a, 32'd1, 1'b1, 1'b1, 1'b1,
            '{gmt_pkg::ST_STALE, 1'b0, gmt_pkg::KIND_UP, 32'd0, 6'd0, 1'b0,
              gmt_pkg::CNT_W'(1), gmt_pkg::CNT_W'(0)});
    add_row(gmt_pkg::OP_DOWN, addr_a, port_a, uid_a, 32'd1, 1'b0, 1'b0, 1'b1,
            '{gmt_pkg::ST_STALE, 1'b0, gmt_pkg::KIND_UP, 32'd0, 6'd0, 1'b0,
              gmt_pkg::CNT_W'(1), gmt_pkg::CNT_W'(0)});
    add_row(gmt_pkg::OP_MERGE, addr_a, port_a, uid_a, 32'd5, 1'b1, 1'b1, 1'b1,
            '{gmt_pkg::ST_APPLIED, 1'b0, gmt_pkg::KIND_UP, 32'd0, 6'd0, 1'b1,
              gmt_pkg::CNT_W'(2), gmt_pkg::CNT_W'(0)});
    add_row(gmt_pkg::OP_UP, addr_a, port_a, uid_a, 32'd5, 1'b0, 1'b0, 1'b1,
            '{gmt_pkg::ST_STALE, 1'b0, gmt_pkg::KIND_UP, 32'd0, 6'd0, 1'b0,
              gmt_pkg::CNT_W'(2), gmt_pkg::CNT_W'(0)});
    add_row(gmt_pkg::OP_UP, addr_a, port_a, uid_a, 32'd7, 1'b0, 1'b0, 1'b1,
            '{gmt_pkg::ST_APPLIED, 1'b1, gmt_pkg::KIND_UP, 32'd7, 6'd3, 1'b1,
              gmt_pkg::CNT_W'(2), gmt_pkg::CNT_W'(0)});
    add_row(gmt_pkg::OP_SUSPECT, addr_a, port_a, uid_a, 32'd7, 1'b0, 1'b0, 1'b1,
            '{gmt_pkg::ST_APPLIED, 1'b1, gmt_pkg::KIND_SUSPECT, 32'd7, 6'd0, 1'b1,
              gmt_pkg::CNT_W'(1), gmt_pkg::CNT_W'(1)});
    add_row(gmt_pkg::OP_SUSPECT, addr_a, port_a, uid_a, 32'd9, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_RECOVER, addr_a, port_a, uid_a, 32'd8, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_RECOVER, addr_a, port_a, uid_a, 32'd9, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_ACTOR_UP, addr_a, port_a, uid_a, 32'd10, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_ACTOR_DN, addr_a, port_a, uid_a, 32'd10, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_PING_FAIL, addr_a, port_a, uid_a, 32'd0, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_PING_OK, addr_a, port_a, uid_a, 32'd0, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_FULL, addr_b, port_b, uid_a, 32'd3, 1'b0, 1'b1, 1'b0, r0);
    // a new instance uid expires the old entry
    add_row(gmt_pkg::OP_UP, addr_a, port_a, 32'h0BAD_0001, 32'd1, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_DOWN, '0, '0, '0, 32'd3, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_MERGE, '1, '1, '1, '1, 1'b1, 1'b1, 1'b0, r0);
    add_row(gmt_pkg::OP_UP, '1, '1, '1, '1, 1'b1, 1'b1, 1'b0, r0);
    add_row(gmt_pkg::OP_DOWN, addr_b, port_b, uid_a, 32'd4, 1'b0, 1'b0, 1'b0, r0);
    add_row(4'd10, addr_a, port_a, uid_a, 32'd4, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_PING_FAIL, addr_b, port_b, uid_a, 32'd0, 1'b0, 1'b0, 1'b0, r0);
    add_row(gmt_pkg::OP_FULL, addr_a, port_a, uid_a, 32'd2, 1'b1, 1'b0, 1'b0, r0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_event(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
    wait_idle();

    new_setting($urandom, 16'($urandom), 4'd15);
    random_phase(12);

    snd_idle = 53;
    rcv_idle = 22;
    new_setting(key_pool[1][47:16], key_pool[1][15:0], 4'd0);
    hold_go <= 1'b1;
    random_phase(12);

    snd_idle = 0;
    rcv_idle = 0;
    // wide key pool so the table runs out of free slots
    new_setting('1, '1, 4'd7);
    random_phase(72);

    new_setting('0, '0, 4'd1);
    random_phase(12);

    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/gmt_pkg.sv
hw/rtl/gmt_cell.sv
hw/rtl/gmt_ctrl.sv
hw/rtl/gossip_membership_table_top.sv
hw/rtl/gmt_checker.sv
sim/gossip_membership_table_top_tb.sv
